// ----- rtl/core/cen_pkg.sv -----
// Shared types, codes and default sizes for the combination enumerator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package cen_pkg;

    // Default sizes handed to the top-level parameters
    localparam int CEN_MAX_K        = 16;
    localparam int CEN_ELEMENT_BITS = 8;
    localparam int CEN_COUNT_BITS   = 48;

    // Fixed field widths of the channels and registers
    localparam int CMD_W      = 2;
    localparam int POS_W      = 4;
    localparam int VAL_W      = 8;
    localparam int SET_SIZE_W = 8;
    localparam int CHOOSE_W   = 5;
    localparam int EXPL_W     = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Width of the binomial loop counter, divisor and remainder
    localparam int BIN_W = 8;

    // Reset values of the configuration registers
    localparam logic [SET_SIZE_W-1:0] SET_SIZE_RST = 8'd8;
    localparam logic [CHOOSE_W-1:0]   CHOOSE_RST   = 5'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_NEXT    = 2'd2
    } cen_cmd_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_SIZE       = 2'd0,
        CFG_CHOOSE_SIZE    = 2'd1,
        CFG_COUNT_SOURCE   = 2'd2,
        CFG_EXPLICIT_COUNT = 2'd3
    } cen_cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXH,
        ST_FIRST,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_REFILL,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_BIN_CHK,
        ST_BIN_DIV1,
        ST_BIN_DIV2
    } cen_state_t;

    // Source of an output word
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_EXH,
        OUT_FIRST,
        OUT_MEM
    } cen_out_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic         do_load;
        logic         do_restart;
        logic         idx_zero;
        logic         idx_last;
        logic         idx_inc;
        logic         idx_dec;
        logic         fill_write;
        logic         refill_write;
        logic         set_cur;
        logic         count_up;
        cen_out_sel_t out_sel;
        logic         bin_begin;
        logic         bin_mid;
        logic         bin_step;
        logic         bin_sat;
        logic         bin_done;
    } cen_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic sizes_ok;
        logic below_limit;
        logic before_first;
        logic need_binom;
        logic idx_is_last;
        logic idx_is_zero;
        logic found;
        logic out_free;
        logic div_done;
        logic bin_end;
        logic bin_ovf;
    } cen_stat_t;

endpackage

// ----- rtl/core/cen_in_if.sv -----
// Command channel: valid/ready handshake carrying one command word.
// Depends on cen_pkg for the field widths.
interface cen_in_if;
    import cen_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] element_position;
    logic [VAL_W-1:0] element_value;

    modport source (output valid, output command, output element_position,
                    output element_value, input ready);
    modport sink   (input valid, input command, input element_position,
                    input element_value, output ready);
endinterface

// ----- rtl/core/cen_out_if.sv -----
// Result channel: valid/ready handshake carrying one element word.
// Depends on cen_pkg for the field widths.
interface cen_out_if;
    import cen_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic             last_of_run;
    logic             exhausted;

    modport source (output valid, output position, output value, output last_of_run,
                    output exhausted, input ready);
    modport sink   (input valid, input position, input value, input last_of_run,
                    input exhausted, output ready);
endinterface

// ----- rtl/core/cen_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the binomial loop.
// Depends on cen_pkg (BIN_W).
module cen_divider #(
    parameter int DW = cen_pkg::CEN_COUNT_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DW-1:0]            dividend,
    input  logic [cen_pkg::BIN_W-1:0] divisor,
    output logic                     done,
    output logic [DW-1:0]            quotient,
    output logic [cen_pkg::BIN_W-1:0] remainder
);
    import cen_pkg::*;

    localparam int CW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [BIN_W-1:0] rem_reg;
    logic [BIN_W-1:0] dvs_reg;

    logic [BIN_W:0]   rem_sh;
    logic [BIN_W+1:0] diff;
    logic             fits;

    // Trial subtraction of the divisor from the shifted remainder
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
        fits   = ~diff[BIN_W+1];
    end

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    // Quotient and remainder shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? diff[BIN_W-1:0] : rem_sh[BIN_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ----- rtl/core/cen_datapath.sv -----
// Datapath: configuration registers, element store, counters, binomial
// registers with their divider, and the output word register.
// Depends on cen_pkg and cen_divider.
module cen_datapath #(
    parameter int MAX_K        = cen_pkg::CEN_MAX_K,
    parameter int ELEMENT_BITS = cen_pkg::CEN_ELEMENT_BITS,
    parameter int COUNT_BITS   = cen_pkg::CEN_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cen_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cen_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [cen_pkg::POS_W-1:0]      element_position,
    input  logic [cen_pkg::VAL_W-1:0]      element_value,
    input  cen_pkg::cen_ctl_t             ctl,
    output cen_pkg::cen_stat_t            stat,
    input  logic                          res_ready,
    output logic                          res_valid,
    output logic [cen_pkg::POS_W-1:0]      res_position,
    output logic [cen_pkg::VAL_W-1:0]      res_value,
    output logic                          res_last,
    output logic                          res_exhausted
);
    import cen_pkg::*;

    localparam int IDX_W  = $clog2(MAX_K);
    localparam int KW     = ((IDX_W > CHOOSE_W) ? IDX_W : CHOOSE_W) + 2;
    localparam int CMP_W  = ((ELEMENT_BITS > SET_SIZE_W + 1) ? ELEMENT_BITS : SET_SIZE_W + 1) + 1;
    localparam int PROD_W = COUNT_BITS + BIN_W + 1;
    localparam int RM_W   = 2 * BIN_W + 1;

    // Configuration registers
    logic [SET_SIZE_W-1:0] set_size_reg;
    logic [CHOOSE_W-1:0]   choose_size_reg;
    logic                  count_source_reg;
    logic [EXPL_W-1:0]     explicit_count_reg;

    // Element store
    logic [ELEMENT_BITS-1:0] elem_mem [MAX_K];
    logic [MAX_K-1:0]        elem_vld_reg;
    logic [ELEMENT_BITS-1:0] rd_data_reg;
    logic                    rd_vld_reg;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [ELEMENT_BITS-1:0] wr_data;
    logic [ELEMENT_BITS-1:0] rd_eff;

    // Walk state
    logic [IDX_W-1:0]        idx_reg;
    logic [ELEMENT_BITS-1:0] cur_reg;
    logic [COUNT_BITS-1:0]   issued_reg;
    logic [COUNT_BITS-1:0]   limit_reg;
    logic                    before_first_reg;

    // Binomial loop
    logic [BIN_W-1:0]      delta_reg;
    logic [BIN_W-1:0]      imax_reg;
    logic [BIN_W-1:0]      bi_reg;
    logic [BIN_W:0]        m_reg;
    logic [COUNT_BITS-1:0] ans_reg;
    logic [COUNT_BITS-1:0] q_reg;
    logic [PROD_W-1:0]     prod_reg;

    logic                  div_start;
    logic [COUNT_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [COUNT_BITS-1:0] div_quo;
    logic [BIN_W-1:0]      div_rem;
    logic [RM_W-1:0]       rm_prod;
    logic [COUNT_BITS:0]   bin_sum;

    logic                  sizes_ok;
    logic                  n_eq_k;
    logic                  pos_ok;
    logic [SET_SIZE_W-1:0] rest;
    logic [COUNT_BITS-1:0] limit_sel;
    logic [CMP_W-1:0]      ceiling;
    logic                  out_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg       <= SET_SIZE_RST;
            choose_size_reg    <= CHOOSE_RST;
            count_source_reg   <= 1'b0;
            explicit_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_SIZE:       set_size_reg       <= cfg_data[SET_SIZE_W-1:0];
                CFG_CHOOSE_SIZE:    choose_size_reg    <= cfg_data[CHOOSE_W-1:0];
                CFG_COUNT_SOURCE:   count_source_reg   <= cfg_data[0];
                CFG_EXPLICIT_COUNT: explicit_count_reg <= cfg_data[EXPL_W-1:0];
                default: ;
            endcase
        end
    end

    // Size checks and limit selection
    always_comb
    begin
        sizes_ok  = (choose_size_reg != '0) && (KW'(choose_size_reg) <= KW'(MAX_K)) &&
                    (SET_SIZE_W'(choose_size_reg) <= set_size_reg);
        n_eq_k    = (set_size_reg == SET_SIZE_W'(choose_size_reg));
        pos_ok    = (KW'(element_position) < KW'(MAX_K));
        rest      = set_size_reg - SET_SIZE_W'(choose_size_reg);
        limit_sel = count_source_reg ? COUNT_BITS'(explicit_count_reg) : limit_reg;
        ceiling   = CMP_W'(set_size_reg) - CMP_W'(choose_size_reg) + CMP_W'(idx_reg);
        rd_eff    = rd_vld_reg ? rd_data_reg : '0;
    end

    // Store write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = cur_reg;
        if (ctl.do_load && pos_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(element_position);
            wr_data = ELEMENT_BITS'(element_value);
        end
        else if (ctl.fill_write)
        begin
            wr_en   = 1'b1;
            wr_data = ELEMENT_BITS'(idx_reg);
        end
        else if (ctl.refill_write)
        begin
            wr_en = 1'b1;
        end
    end

    // Store array, read at the walk index
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            elem_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= elem_mem[idx_reg];
    end

    // Written marks; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                elem_vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= elem_vld_reg[idx_reg];
        end
    end

    // Walk index, running value, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg          <= '0;
            cur_reg          <= '0;
            issued_reg       <= '0;
            limit_reg        <= '0;
            before_first_reg <= 1'b1;
        end
        else
        begin
            if (ctl.idx_zero)
            begin
                idx_reg <= '0;
            end
            else if (ctl.idx_last)
            begin
                idx_reg <= IDX_W'(choose_size_reg - CHOOSE_W'(1));
            end
            else if (ctl.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            else if (ctl.idx_dec)
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end

            if (ctl.set_cur)
            begin
                cur_reg <= rd_eff + ELEMENT_BITS'(1);
            end
            else if (ctl.refill_write)
            begin
                cur_reg <= cur_reg + ELEMENT_BITS'(1);
            end

            if (ctl.do_load)
            begin
                issued_reg       <= '0;
                before_first_reg <= 1'b0;
            end
            else if (ctl.do_restart)
            begin
                issued_reg       <= '0;
                before_first_reg <= 1'b1;
                if (!count_source_reg)
                begin
                    if (!sizes_ok)
                    begin
                        limit_reg <= '0;
                    end
                    else if (n_eq_k)
                    begin
                        limit_reg <= COUNT_BITS'(1);
                    end
                end
            end
            else if (ctl.count_up)
            begin
                issued_reg       <= issued_reg + COUNT_BITS'(1);
                before_first_reg <= 1'b0;
            end
            else if (ctl.bin_sat)
            begin
                limit_reg <= '1;
            end
            else if (ctl.bin_done)
            begin
                limit_reg <= ans_reg;
            end
        end
    end

    // Binomial loop registers
    always_ff @(posedge clk)
    begin
        if (ctl.do_restart)
        begin
            delta_reg <= (SET_SIZE_W'(choose_size_reg) < rest) ? rest
                         : SET_SIZE_W'(choose_size_reg);
            imax_reg  <= (SET_SIZE_W'(choose_size_reg) < rest)
                         ? SET_SIZE_W'(choose_size_reg) : rest;
            ans_reg   <= COUNT_BITS'((SET_SIZE_W'(choose_size_reg) < rest) ? rest
                         : SET_SIZE_W'(choose_size_reg)) + COUNT_BITS'(1);
            bi_reg    <= BIN_W'(2);
        end
        else if (ctl.bin_step)
        begin
            ans_reg <= bin_sum[COUNT_BITS-1:0];
            bi_reg  <= bi_reg + BIN_W'(1);
        end
        if (ctl.bin_begin)
        begin
            m_reg <= (BIN_W + 1)'(delta_reg) + (BIN_W + 1)'(bi_reg);
        end
        if (ctl.bin_mid)
        begin
            q_reg <= div_quo;
        end
        prod_reg <= PROD_W'(q_reg) * PROD_W'(m_reg);
    end

    // Shared divider: ans / i, then (r * m) / i
    assign rm_prod      = RM_W'(div_rem) * RM_W'(m_reg);
    assign div_start    = ctl.bin_begin | ctl.bin_mid;
    assign div_dividend = ctl.bin_mid ? COUNT_BITS'(rm_prod) : ans_reg;
    assign bin_sum      = {1'b0, prod_reg[COUNT_BITS-1:0]} + {1'b0, div_quo};

    cen_divider #(
        .DW (COUNT_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (bi_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Output word register
    assign out_free = ~res_valid | res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
        end
        else if (ctl.out_sel != OUT_NONE)
        begin
            res_valid <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.out_sel)
            OUT_EXH:
            begin
                res_position  <= '0;
                res_value     <= '0;
                res_last      <= 1'b1;
                res_exhausted <= 1'b1;
            end
            OUT_FIRST:
            begin
                res_position  <= POS_W'(idx_reg);
                res_value     <= VAL_W'(idx_reg);
                res_last      <= stat.idx_is_last;
                res_exhausted <= 1'b0;
            end
            OUT_MEM:
            begin
                res_position  <= POS_W'(idx_reg);
                res_value     <= VAL_W'(rd_eff);
                res_last      <= stat.idx_is_last;
                res_exhausted <= 1'b0;
            end
            default: ;
        endcase
    end

    // Status back to the controller
    always_comb
    begin
        stat.sizes_ok     = sizes_ok;
        stat.below_limit  = (issued_reg < limit_sel);
        stat.before_first = before_first_reg;
        stat.need_binom   = ~count_source_reg & sizes_ok & ~n_eq_k;
        stat.idx_is_last  = (KW'(idx_reg) == KW'(choose_size_reg) - KW'(1));
        stat.idx_is_zero  = (idx_reg == '0);
        stat.found        = (CMP_W'(rd_eff) < ceiling);
        stat.out_free     = out_free;
        stat.div_done     = div_done;
        stat.bin_end      = (bi_reg > imax_reg);
        stat.bin_ovf      = (|prod_reg[PROD_W-1:COUNT_BITS]) | bin_sum[COUNT_BITS];
    end
endmodule

// ----- rtl/core/cen_ctrl.sv -----
// Controller state machine: decodes commands and sequences the search,
// refill, emission and binomial steps of the datapath.
// Depends on cen_pkg.
module cen_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic [cen_pkg::CMD_W-1:0] command,
    input  cen_pkg::cen_stat_t       stat,
    output logic                     item_ready,
    output cen_pkg::cen_ctl_t        ctl
);
    import cen_pkg::*;

    cen_state_t state_reg;
    cen_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        ctl        = '0;
        ctl.out_sel = OUT_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    case (command)
                        CMD_LOAD:
                        begin
                            ctl.do_load = 1'b1;
                        end
                        CMD_RESTART:
                        begin
                            ctl.do_restart = 1'b1;
                            if (stat.need_binom)
                            begin
                                state_next = ST_BIN_CHK;
                            end
                        end
                        CMD_NEXT:
                        begin
                            if (!stat.sizes_ok || !stat.below_limit)
                            begin
                                state_next = ST_EXH;
                            end
                            else if (stat.before_first)
                            begin
                                ctl.idx_zero = 1'b1;
                                state_next   = ST_FIRST;
                            end
                            else
                            begin
                                ctl.idx_last = 1'b1;
                                state_next   = ST_SRCH_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXH:
            begin
                if (stat.out_free)
                begin
                    ctl.out_sel = OUT_EXH;
                    state_next  = ST_IDLE;
                end
            end
            // First combination: write and emit 0..k-1
            ST_FIRST:
            begin
                if (stat.out_free)
                begin
                    ctl.fill_write = 1'b1;
                    ctl.out_sel    = OUT_FIRST;
                    if (stat.idx_is_last)
                    begin
                        ctl.count_up = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        ctl.idx_inc = 1'b1;
                    end
                end
            end
            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end
            // Rightmost element below its ceiling
            ST_SRCH_CMP:
            begin
                if (stat.found)
                begin
                    ctl.set_cur = 1'b1;
                    state_next  = ST_REFILL;
                end
                else if (stat.idx_is_zero)
                begin
                    state_next = ST_EXH;
                end
                else
                begin
                    ctl.idx_dec = 1'b1;
                    state_next  = ST_SRCH_RD;
                end
            end
            ST_REFILL:
            begin
                ctl.refill_write = 1'b1;
                if (stat.idx_is_last)
                begin
                    ctl.count_up = 1'b1;
                    ctl.idx_zero = 1'b1;
                    state_next   = ST_EMIT_RD;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (stat.out_free)
                begin
                    ctl.out_sel = OUT_MEM;
                    if (stat.idx_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ctl.idx_inc = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            // Binomial: one multiply-then-divide term per pass
            ST_BIN_CHK:
            begin
                if (stat.bin_end)
                begin
                    ctl.bin_done = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ctl.bin_begin = 1'b1;
                    state_next    = ST_BIN_DIV1;
                end
            end
            ST_BIN_DIV1:
            begin
                if (stat.div_done)
                begin
                    ctl.bin_mid = 1'b1;
                    state_next  = ST_BIN_DIV2;
                end
            end
            ST_BIN_DIV2:
            begin
                if (stat.div_done)
                begin
                    if (stat.bin_ovf)
                    begin
                        ctl.bin_sat = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        ctl.bin_step = 1'b1;
                        state_next   = ST_BIN_CHK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/core/combination_enumerator_unit.sv -----
// Channel     | Dir | Handshake     | Word
// ------------+-----+---------------+-------------------------------------------
// item        | in  | valid/ready   | command, element_position, element_value
// result      | out | valid/ready   | position, value, last_of_run, exhausted
// cfg         | in  | cfg_we strobe | cfg_index, cfg_data
//
// Load, unknown codes and a plain restart are handled in the idle state. A restart with
// a computed limit runs the bit-serial divider twice per binomial term and stops early
// when the limit saturates. Next writes and emits 0..k-1 for the first combination;
// later it scans down for the element to bump, refills the positions after it and emits
// the k words. An exhausted walk, or one where nothing advances, gives an exhausted word.
// Output stalls hold the emission; reset is asynchronous, active low, config to defaults.
// Top level of the combination enumerator. Depends on cen_pkg, cen_in_if,
// cen_out_if, cen_ctrl and cen_datapath.
module combination_enumerator_unit #(
    parameter int MAX_K        = cen_pkg::CEN_MAX_K,
    parameter int ELEMENT_BITS = cen_pkg::CEN_ELEMENT_BITS,
    parameter int COUNT_BITS   = cen_pkg::CEN_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cen_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cen_pkg::CFG_DATA_W-1:0] cfg_data,
    cen_in_if.sink                        item,
    cen_out_if.source                     result
);
    import cen_pkg::*;

    cen_ctl_t  ctl;
    cen_stat_t stat;
    logic      item_ready;

    assign item.ready = item_ready;

    // Controller
    cen_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .command    (item.command),
        .stat       (stat),
        .item_ready (item_ready),
        .ctl        (ctl)
    );

    // Datapath
    cen_datapath #(
        .MAX_K        (MAX_K),
        .ELEMENT_BITS (ELEMENT_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .element_position (item.element_position),
        .element_value    (item.element_value),
        .ctl              (ctl),
        .stat             (stat),
        .res_ready        (result.ready),
        .res_valid        (result.valid),
        .res_position     (result.position),
        .res_value        (result.value),
        .res_last         (result.last_of_run),
        .res_exhausted    (result.exhausted)
    );
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for combination_enumerator_unit: directed and random command
// streams, with a scoreboard that tracks the combination walk and checks each word.
// Depends on cen_pkg, cen_in_if, cen_out_if and the enumerator RTL.
module tb_top;
    import cen_pkg::*;

    localparam logic [CMD_W-1:0]          CMD_UNKNOWN = 2'd3;
    localparam logic [CEN_COUNT_BITS-1:0] COUNT_FULL  = '1;
    localparam int                        SETTLE_CYCLES = 2000;
    localparam int                        DRAIN_LIMIT   = 20000;

    typedef struct {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             last;
        logic             exh;
    } elem_word_t;

    // Scoreboard: own copy of the registers and of the walk state
    class comb_scoreboard;
        logic [SET_SIZE_W-1:0]     n_items;
        logic [CHOOSE_W-1:0]       k_pick;
        logic                      use_explicit;
        logic [EXPL_W-1:0]         explicit_limit;
        logic [VAL_W-1:0]          elems [CEN_MAX_K];
        logic [CEN_COUNT_BITS-1:0] issued;
        logic [CEN_COUNT_BITS-1:0] computed_limit;
        logic                      fresh;
        elem_word_t                pending_words [$];
        int                        errors;

        function new();
            n_items        = SET_SIZE_RST;
            k_pick         = CHOOSE_RST;
            use_explicit   = 1'b0;
            explicit_limit = '0;
            foreach (elems[p]) elems[p] = '0;
            issued         = '0;
            computed_limit = '0;
            fresh          = 1'b1;
            errors         = 0;
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function void set_reg(cen_cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_SET_SIZE:       n_items        = d[SET_SIZE_W-1:0];
                CFG_CHOOSE_SIZE:    k_pick         = d[CHOOSE_W-1:0];
                CFG_COUNT_SOURCE:   use_explicit   = d[0];
                CFG_EXPLICIT_COUNT: explicit_limit = d[EXPL_W-1:0];
                default: ;
            endcase
        endfunction

        function bit sizes_ok();
            return k_pick != '0 && 32'(k_pick) <= CEN_MAX_K &&
                   SET_SIZE_W'(k_pick) <= n_items;
        endfunction

        // C(n,k) built up term by term as C(n-lo+i, i); every step divides exactly
        function logic [CEN_COUNT_BITS-1:0] binomial_limit(int unsigned n, int unsigned k);
            int unsigned     lo;
            longint unsigned c;
            lo = (k < n - k) ? k : n - k;
            c  = 1;
            for (int unsigned i = 1; i <= lo; i++) begin
                c = c * 64'(n - lo + i) / 64'(i);
                if (c > 64'(COUNT_FULL))
                    return COUNT_FULL;
            end
            return c[CEN_COUNT_BITS-1:0];
        endfunction

        function void push_exhausted();
            elem_word_t w;
            w.pos  = '0;
            w.val  = '0;
            w.last = 1'b1;
            w.exh  = 1'b1;
            pending_words.push_back(w);
        endfunction

        // Step to the successor combination and queue its k words, or queue an exhausted word
        function void advance();
            int unsigned               n;
            int unsigned               k;
            int unsigned               i;
            bit                        found;
            logic [CEN_COUNT_BITS-1:0] lim;
            elem_word_t                w;
            n   = 32'(n_items);
            k   = 32'(k_pick);
            lim = use_explicit ? explicit_limit[CEN_COUNT_BITS-1:0] : computed_limit;
            if (!sizes_ok() || issued >= lim) begin
                push_exhausted();
                return;
            end
            if (fresh) begin
                for (int unsigned p = 0; p < k; p++)
                    elems[p] = VAL_W'(p);
                fresh = 1'b0;
            end else begin
                // rightmost element still below its ceiling; ones loaded above it are passed over
                i     = k;
                found = 1'b0;
                while (!found && i > 0) begin
                    i--;
                    if (32'(elems[i]) < n - k + i)
                        found = 1'b1;
                end
                if (!found) begin
                    push_exhausted();
                    return;
                end
                elems[i] = elems[i] + VAL_W'(1);
                for (int unsigned p = i + 1; p < k; p++)
                    elems[p] = VAL_W'(32'(elems[i]) + (p - i));
            end
            issued = issued + CEN_COUNT_BITS'(1);
            for (int unsigned p = 0; p < k; p++) begin
                w.pos  = POS_W'(p);
                w.val  = elems[p];
                w.last = (p == k - 1);
                w.exh  = 1'b0;
                pending_words.push_back(w);
            end
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] val);
            case (cmd)
                CMD_LOAD:
                begin
                    elems[pos] = val;
                    issued     = '0;
                    fresh      = 1'b0;
                end
                CMD_RESTART:
                begin
                    fresh  = 1'b1;
                    issued = '0;
                    if (!use_explicit)
                        computed_limit = sizes_ok()
                                         ? binomial_limit(32'(n_items), 32'(k_pick)) : '0;
                end
                CMD_NEXT: advance();
                default: ;
            endcase
        endfunction

        task check_result(elem_word_t got);
            elem_word_t want;
            if (pending_words.size() == 0) begin
                report($sformatf("word with nothing expected: pos=%0d val=%0d last=%0b exh=%0b",
                                 got.pos, got.val, got.last, got.exh));
                return;
            end
            want = pending_words.pop_front();
            if (got.pos !== want.pos)
                report($sformatf("position %0d, expected %0d", got.pos, want.pos));
            if (got.val !== want.val)
                report($sformatf("value %0d, expected %0d", got.val, want.val));
            if (got.last !== want.last)
                report($sformatf("last_of_run %0b, expected %0b", got.last, want.last));
            if (got.exh !== want.exh)
                report($sformatf("exhausted %0b, expected %0b", got.exh, want.exh));
        endtask

        task flush_leftovers();
            while (pending_words.size() != 0) begin
                report($sformatf("word never arrived: pos=%0d val=%0d",
                                 pending_words[0].pos, pending_words[0].val));
                void'(pending_words.pop_front());
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm;

    cen_in_if  cmd_bus ();
    cen_out_if elem_bus ();

    comb_scoreboard sb = new();

    combination_enumerator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (cmd_bus),
        .result    (elem_bus)
    );

    always #2 clk = ~clk;

    // Result side: check accepted words, then decide on stalling the next cycle
    always @(posedge clk)
    begin
        elem_word_t got;
        if (rst_n && elem_bus.valid && elem_bus.ready) begin
            got.pos  = elem_bus.position;
            got.val  = elem_bus.value;
            got.last = elem_bus.last_of_run;
            got.exh  = elem_bus.exhausted;
            sb.check_result(got);
        end
        elem_bus.ready <= calm || ($urandom_range(99) >= 13);
    end

    // Present one command word, with random idle cycles ahead of it
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                             input logic [VAL_W-1:0] v);
        while (!calm && $urandom_range(99) < 13) begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid            <= 1'b1;
        cmd_bus.command          <= c;
        cmd_bus.element_position <= p;
        cmd_bus.element_value    <= v;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        sb.note_item(c, p, v);
    endtask

    task automatic send_next();
        send_item(CMD_NEXT, POS_W'($urandom_range(15)), VAL_W'($urandom_range(255)));
    endtask

    task automatic send_restart();
        send_item(CMD_RESTART, POS_W'($urandom_range(15)), VAL_W'($urandom_range(255)));
    endtask

    task automatic write_reg(input cen_cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.set_reg(idx, d);
    endtask

    task automatic apply_setup(input int unsigned n, input int unsigned k, input bit src,
                               input logic [EXPL_W-1:0] expl);
        write_reg(CFG_SET_SIZE, CFG_DATA_W'(n));
        write_reg(CFG_CHOOSE_SIZE, CFG_DATA_W'(k));
        write_reg(CFG_COUNT_SOURCE, CFG_DATA_W'(src));
        write_reg(CFG_EXPLICIT_COUNT, expl);
        cfg_we <= 1'b0;
    endtask

    // Wait for all expected words, then for any restart still computing its limit
    task automatic settle();
        int waited;
        cmd_bus.valid <= 1'b0;
        waited = 0;
        while (sb.pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        sb.flush_leftovers();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load a valid start combination with random content; returns words sent
    task automatic load_walk(input int unsigned n, input int unsigned k, output int sent);
        int unsigned lo;
        int unsigned v;
        lo = 0;
        for (int unsigned p = 0; p < k; p++) begin
            v  = $urandom_range(n - k + p, lo);
            lo = v + 1;
            send_item(CMD_LOAD, POS_W'(p), VAL_W'(v));
        end
        sent = k;
    endtask

    task automatic random_phase(input int quota);
        int unsigned       n;
        int unsigned       k;
        bit                src;
        logic [EXPL_W-1:0] expl;
        int                done;
        int                r;
        int                sent;
        r = $urandom_range(99);
        if (r < 60) begin
            n = $urandom_range(12, 1);
            k = $urandom_range((n < 5) ? n : 5, 1);
        end else if (r < 75) begin
            n = $urandom_range(255, 17);
            k = $urandom_range(16, 1);
        end else if (r < 87) begin
            n = $urandom_range(20, 16);
            k = $urandom_range(16, 12);
        end else begin
            // sizes the walk cannot use
            case ($urandom_range(2))
                0:       begin n = $urandom_range(255, 1); k = 0; end
                1:       begin n = $urandom_range(255, 1); k = $urandom_range(31, 17); end
                default: begin n = $urandom_range(15, 1);  k = n + 1; end
            endcase
        end
        src = ($urandom_range(99) < 30);
        r   = $urandom_range(99);
        if (r < 70)
            expl = EXPL_W'($urandom_range(40, 0));
        else if (r < 90)
            expl = EXPL_W'({$urandom(), $urandom()});
        else
            expl = '1;
        apply_setup(n, k, src, expl);

        done = 0;
        if ($urandom_range(99) < 85) begin
            send_restart();
            done++;
        end
        while (done < quota) begin
            r = $urandom_range(99);
            if (r < 70) begin
                send_next();
                done++;
            end else if (r < 78) begin
                send_restart();
                done++;
            end else if (r < 87 && k >= 1 && k <= CEN_MAX_K && k <= n) begin
                load_walk(n, k, sent);
                done += sent;
            end else if (r < 95) begin
                send_item(CMD_LOAD, POS_W'($urandom_range(15)), VAL_W'($urandom_range(255)));
                done++;
            end else begin
                send_item(CMD_UNKNOWN, POS_W'($urandom_range(15)),
                          VAL_W'($urandom_range(255)));
                done++;
            end
        end
        settle();
    endtask

    // Run cap
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = CFG_SET_SIZE;
        cfg_data                 = '0;
        calm                     = 1'b0;
        cmd_bus.valid            = 1'b0;
        cmd_bus.command          = CMD_LOAD;
        cmd_bus.element_position = '0;
        cmd_bus.element_value    = '0;
        elem_bus.ready           = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: limit still zero, ignored code, restart, stuck and over-ceiling loads
        send_next();
        send_item(CMD_UNKNOWN, 4'hF, 8'hFF);
        send_restart();
        send_next();
        send_next();
        send_item(CMD_LOAD, 4'd0, 8'd6);
        send_item(CMD_LOAD, 4'd1, 8'd7);
        send_next();
        send_item(CMD_LOAD, 4'd0, 8'd255);
        send_item(CMD_LOAD, 4'd1, 8'd3);
        send_next();
        send_item(CMD_LOAD, 4'd15, 8'd0);
        settle();

        // k equal to n: one combination covering all sixteen positions
        apply_setup(16, 16, 1'b0, '0);
        send_restart();
        send_next();
        send_next();
        settle();

        // Largest sizes: binomial saturates
        apply_setup(255, 16, 1'b0, '0);
        send_restart();
        send_next();
        send_next();
        settle();

        // k of zero
        apply_setup(1, 0, 1'b0, '0);
        send_restart();
        send_next();
        settle();

        // Explicit limit reached after two combinations
        apply_setup(5, 2, 1'b1, EXPL_W'(2));
        send_restart();
        send_next();
        send_next();
        send_next();
        settle();

        for (int ph = 0; ph < 10; ph++) begin
            calm = (ph == 4 || ph == 5);
            random_phase(45);
        end
        calm = 1'b0;
        settle();

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
